[rtl/line_strip_end_extender_top_assert.svh]
// ---------------------------------------------------------------------------
// Line strip end extender assertion macros
// Shared concurrent assertion forms used by the extender RTL.
// ---------------------------------------------------------------------------
`ifndef LINE_STRIP_END_EXTENDER_TOP_ASSERT_SVH
`define LINE_STRIP_END_EXTENDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSEE_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsee: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LSEE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsee: next-cycle check failed");

`endif

[rtl/lsee_pkg.sv]
// ---------------------------------------------------------------------------
// Line strip end extender package
// Widths, register indexes, reset values and the color type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsee_pkg;

  localparam int POS_WIDTH_DEFAULT = 32;
  localparam int COLOR_WIDTH       = 16;
  localparam int DIST_WIDTH        = 16;
  localparam int CFG_INDEX_WIDTH   = 2;
  localparam int CFG_DATA_WIDTH    = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXTEND_DISTANCE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH      = 2'd1;

  localparam logic [DIST_WIDTH-1:0] EXTEND_DISTANCE_RESET = 16'd7;
  localparam logic [DIST_WIDTH-1:0] MIN_LENGTH_RESET      = 16'd1;

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] red;
    logic [COLOR_WIDTH-1:0] green;
    logic [COLOR_WIDTH-1:0] blue;
  } color_t;

endpackage

`default_nettype wire

[rtl/line_strip_end_extender_top.sv]
// Line strip end extender. Vertices of a strip come in one beat at a time and
// leave with one extrapolated vertex added before the first and after the last
// vertex; each vertex goes out one input beat late (at once when it carries
// in_last). A strip of a single vertex produces nothing. The input side takes
// a beat only while the sequencer is idle. A first vertex is only taken; a
// middle vertex is taken, then loaded into the output register. Each added end
// vertex is worked out in one shared adder/subtractor that walks the
// differences, the serial squares, the digit-by-digit square root, the serial
// products with extend_distance and the restoring divisions, one bit or one
// digit per cycle. Output stalls hold the sequencer in its emit states.
// Configuration writes are always taken (cfg_ready is high) and are meant to
// arrive only while no strip is in flight.
// ---------------------------------------------------------------------------
// Line strip end extender, top level
// Sequencer and shared arithmetic unit that add adjacency end vertices.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_strip_end_extender_top_assert.svh"

module line_strip_end_extender_top #(
  parameter int POS_WIDTH = lsee_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lsee_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [lsee_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  // input vertices
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [POS_WIDTH-1:0]             in_x,
  input  logic signed [POS_WIDTH-1:0]             in_y,
  input  logic signed [POS_WIDTH-1:0]             in_z,
  input  logic [lsee_pkg::COLOR_WIDTH-1:0]        in_red,
  input  logic [lsee_pkg::COLOR_WIDTH-1:0]        in_green,
  input  logic [lsee_pkg::COLOR_WIDTH-1:0]        in_blue,
  input  logic                                    in_last,
  // output vertices
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [POS_WIDTH-1:0]             out_x,
  output logic signed [POS_WIDTH-1:0]             out_y,
  output logic signed [POS_WIDTH-1:0]             out_z,
  output logic [lsee_pkg::COLOR_WIDTH-1:0]        out_red,
  output logic [lsee_pkg::COLOR_WIDTH-1:0]        out_green,
  output logic [lsee_pkg::COLOR_WIDTH-1:0]        out_blue,
  output logic                                    out_added,
  output logic                                    out_last
);

  localparam int DW = lsee_pkg::DIST_WIDTH;
  localparam int K  = POS_WIDTH + 1;          // magnitude and root width
  localparam int AW = 2 * POS_WIDTH + 2;      // shared adder width
  localparam int NW = POS_WIDTH + 1 + DW;     // dividend width
  localparam int CW = $clog2(NW);

  localparam logic [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_LATER = 2'd2;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIFF      = 4'd1;
  localparam logic [3:0] S_SQ        = 4'd2;
  localparam logic [3:0] S_SQRT      = 4'd3;
  localparam logic [3:0] S_LEN       = 4'd4;
  localparam logic [3:0] S_MUL       = 4'd5;
  localparam logic [3:0] S_DIV       = 4'd6;
  localparam logic [3:0] S_SUM       = 4'd7;
  localparam logic [3:0] S_EMIT_EXT  = 4'd8;
  localparam logic [3:0] S_EMIT_HELD = 4'd9;
  localparam logic [3:0] S_EMIT_CUR  = 4'd10;

  // control
  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [DW-1:0] extend_distance, min_length;

  // vertex storage
  logic [POS_WIDTH-1:0] held_x, held_y, held_z;
  logic [POS_WIDTH-1:0] cur_x, cur_y, cur_z;
  lsee_pkg::color_t     held_color, cur_color;
  logic                 cur_last;
  logic                 ext_end;

  // extrapolation datapath
  logic [1:0]           comp, load_idx;
  logic [K-1:0]         dmag [3];
  logic [2:0]           dneg;
  logic [K-1:0]         dmag_sel;
  logic [AW-1:0]        acc, mcand;
  logic [K-1:0]         mplier;
  logic [K:0]           rem;
  logic [K-1:0]         root, len;
  logic [DW-1:0]        quo;
  logic [CW-1:0]        cnt;
  logic [POS_WIDTH-1:0] res_pos [3];

  // shared adder/subtractor
  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_sum;
  logic [AW-1:0] alu_res;
  logic          alu_ge;

  logic [POS_WIDTH-1:0] base_pos, oth_pos;
  logic [K+2:0]         sq_ext;
  logic [K:0]           div_ext;
  logic [K-1:0]         floor_len;
  logic [K-1:0]         d_mag;
  logic                 d_neg;
  logic                 pos_ovf, neg_ovf;
  logic [POS_WIDTH-1:0] sat_val;
  logic [K:0]           root_dbl;

  logic in_take, out_free, emit_go;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit_go   = out_free && ((state == S_EMIT_EXT) || (state == S_EMIT_HELD) ||
                                  (state == S_EMIT_CUR));

  assign load_idx  = (comp == 2'd2) ? 2'd0 : comp + 2'd1;
  assign dmag_sel  = dmag[load_idx];
  assign floor_len = (min_length == '0) ? K'(1) : {{(K-DW){1'b0}}, min_length};
  assign sq_ext    = {rem, acc[AW-1:AW-2]};
  assign div_ext   = {rem[K-1:0], acc[NW-1]};
  assign root_dbl  = {root, 1'b0};

  // extrapolation runs from the held vertex at the start, from the current at the end
  always_comb begin
    unique case (comp)
      2'd0:    begin
        base_pos = ext_end ? cur_x : held_x;
        oth_pos  = ext_end ? held_x : cur_x;
      end
      2'd1:    begin
        base_pos = ext_end ? cur_y : held_y;
        oth_pos  = ext_end ? held_y : cur_y;
      end
      default: begin
        base_pos = ext_end ? cur_z : held_z;
        oth_pos  = ext_end ? held_z : cur_z;
      end
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_DIFF: begin
        alu_a   = {{(AW-POS_WIDTH){base_pos[POS_WIDTH-1]}}, base_pos};
        alu_b   = {{(AW-POS_WIDTH){oth_pos[POS_WIDTH-1]}}, oth_pos};
        alu_sub = 1'b1;
      end
      S_SQ, S_MUL: begin
        alu_a = acc;
        alu_b = mcand;
      end
      S_SQRT: begin
        alu_a   = {{(AW-K-3){1'b0}}, sq_ext};
        alu_b   = {{(AW-K-2){1'b0}}, root, 2'b01};
        alu_sub = 1'b1;
      end
      S_LEN: begin
        alu_a   = {{(AW-K){1'b0}}, root};
        alu_b   = {{(AW-K){1'b0}}, floor_len};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {{(AW-K-1){1'b0}}, div_ext};
        alu_b   = {{(AW-K){1'b0}}, len};
        alu_sub = 1'b1;
      end
      S_SUM: begin
        alu_a   = {{(AW-POS_WIDTH){base_pos[POS_WIDTH-1]}}, base_pos};
        alu_b   = {{(AW-DW){1'b0}}, quo};
        alu_sub = dneg[comp];
      end
      default: ;
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {AW{alu_sub}}} + {{AW{1'b0}}, alu_sub};
  assign alu_res = alu_sum[AW-1:0];
  assign alu_ge  = alu_sum[AW];

  assign d_neg = alu_res[K-1];
  assign d_mag = d_neg ? (~alu_res[K-1:0] + K'(1)) : alu_res[K-1:0];

  // clamp the offset vertex to the signed position range
  assign pos_ovf = !alu_res[POS_WIDTH+1] && (alu_res[POS_WIDTH] || alu_res[POS_WIDTH-1]);
  assign neg_ovf = alu_res[POS_WIDTH+1] && !(alu_res[POS_WIDTH] && alu_res[POS_WIDTH-1]);
  assign sat_val = pos_ovf ? POS_MAX : (neg_ovf ? POS_MIN : alu_res[POS_WIDTH-1:0]);

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          unique case (phase)
            PH_NONE:  phase_next = in_last ? PH_NONE : PH_FIRST;
            PH_FIRST: state_next = S_DIFF;
            default:  state_next = S_EMIT_HELD;
          endcase
        end
      end
      S_DIFF:  if (comp == 2'd2) state_next = S_SQ;
      S_SQ:    if (cnt == CW'(K - 1) && comp == 2'd2) state_next = S_SQRT;
      S_SQRT:  if (cnt == CW'(K - 1)) state_next = S_LEN;
      S_LEN:   state_next = S_MUL;
      S_MUL:   if (cnt == CW'(DW - 1)) state_next = S_DIV;
      S_DIV:   if (cnt == CW'(NW - 1)) state_next = S_SUM;
      S_SUM:   state_next = (comp == 2'd2) ? S_EMIT_EXT : S_MUL;
      S_EMIT_EXT: begin
        if (out_free) begin
          state_next = ext_end ? S_IDLE : S_EMIT_HELD;
          if (ext_end) phase_next = PH_NONE;
        end
      end
      S_EMIT_HELD: begin
        if (out_free) begin
          state_next = cur_last ? S_EMIT_CUR : S_IDLE;
          if (!cur_last) phase_next = PH_LATER;
        end
      end
      S_EMIT_CUR: if (out_free) state_next = S_DIFF;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_NONE;
      out_valid       <= 1'b0;
      extend_distance <= lsee_pkg::EXTEND_DISTANCE_RESET;
      min_length      <= lsee_pkg::MIN_LENGTH_RESET;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lsee_pkg::REG_EXTEND_DISTANCE: extend_distance <= cfg_data;
          lsee_pkg::REG_MIN_LENGTH:      min_length      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_x     <= in_x;
      cur_y     <= in_y;
      cur_z     <= in_z;
      cur_color <= '{red: in_red, green: in_green, blue: in_blue};
      cur_last  <= in_last;
      ext_end   <= 1'b0;
      comp      <= 2'd0;
      if (phase == PH_NONE && !in_last) begin
        held_x     <= in_x;
        held_y     <= in_y;
        held_z     <= in_z;
        held_color <= '{red: in_red, green: in_green, blue: in_blue};
      end
    end

    unique case (state)
      S_DIFF: begin
        dneg[comp] <= d_neg;
        dmag[comp] <= d_mag;
        comp       <= load_idx;
        if (comp == 2'd2) begin
          acc    <= '0;
          cnt    <= '0;
          mcand  <= {{(AW-K){1'b0}}, dmag_sel};
          mplier <= dmag_sel;
        end
      end
      S_SQ: begin
        // sum of squares builds up in acc across all three components
        if (mplier[0]) acc <= alu_res;
        if (cnt == CW'(K - 1)) begin
          cnt <= '0;
          if (comp == 2'd2) begin
            rem  <= '0;
            root <= '0;
          end else begin
            comp   <= load_idx;
            mcand  <= {{(AW-K){1'b0}}, dmag_sel};
            mplier <= dmag_sel;
          end
        end else begin
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + CW'(1);
        end
      end
      S_SQRT: begin
        // one root digit per cycle, radicand bit pairs taken from the top of acc
        acc <= acc << 2;
        cnt <= cnt + CW'(1);
        if (alu_ge) begin
          rem  <= alu_res[K:0];
          root <= {root[K-2:0], 1'b1};
        end else begin
          rem  <= sq_ext[K:0];
          root <= {root[K-2:0], 1'b0};
        end
      end
      S_LEN: begin
        len    <= alu_ge ? root : floor_len;
        comp   <= load_idx;
        acc    <= '0;
        cnt    <= '0;
        mcand  <= {{(AW-K){1'b0}}, dmag_sel};
        mplier <= {{(K-DW){1'b0}}, extend_distance};
      end
      S_MUL: begin
        if (mplier[0]) acc <= alu_res;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (cnt == CW'(DW - 1)) begin
          cnt <= '0;
          rem <= '0;
          quo <= '0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      S_DIV: begin
        // restoring division, dividend shifted out of acc one bit per cycle
        acc <= acc << 1;
        quo <= {quo[DW-2:0], alu_ge};
        if (alu_ge) begin
          rem <= {1'b0, alu_res[K-1:0]};
        end else begin
          rem <= div_ext;
        end
        if (cnt == CW'(NW - 1)) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      S_SUM: begin
        res_pos[comp] <= sat_val;
        if (comp != 2'd2) begin
          comp   <= load_idx;
          acc    <= '0;
          cnt    <= '0;
          mcand  <= {{(AW-K){1'b0}}, dmag_sel};
          mplier <= {{(K-DW){1'b0}}, extend_distance};
        end
      end
      S_EMIT_HELD: begin
        if (out_free && !cur_last) begin
          held_x     <= cur_x;
          held_y     <= cur_y;
          held_z     <= cur_z;
          held_color <= cur_color;
        end
      end
      S_EMIT_CUR: begin
        if (out_free) begin
          ext_end <= 1'b1;
          comp    <= 2'd0;
        end
      end
      default: ;
    endcase

    if (emit_go) begin
      unique case (state)
        S_EMIT_EXT: begin
          out_x     <= res_pos[0];
          out_y     <= res_pos[1];
          out_z     <= res_pos[2];
          out_red   <= ext_end ? cur_color.red   : held_color.red;
          out_green <= ext_end ? cur_color.green : held_color.green;
          out_blue  <= ext_end ? cur_color.blue  : held_color.blue;
          out_added <= 1'b1;
          out_last  <= ext_end;
        end
        S_EMIT_HELD: begin
          out_x     <= held_x;
          out_y     <= held_y;
          out_z     <= held_z;
          out_red   <= held_color.red;
          out_green <= held_color.green;
          out_blue  <= held_color.blue;
          out_added <= 1'b0;
          out_last  <= 1'b0;
        end
        default: begin
          out_x     <= cur_x;
          out_y     <= cur_y;
          out_z     <= cur_z;
          out_red   <= cur_color.red;
          out_green <= cur_color.green;
          out_blue  <= cur_color.blue;
          out_added <= 1'b0;
          out_last  <= 1'b0;
        end
      endcase
    end
  end

  `LSEE_ASSERT_HOLDS(a_sqrt_rem_bound, clk, rst, state == S_SQRT, rem <= root_dbl)
  `LSEE_ASSERT_HOLDS(a_div_rem_bound, clk, rst, state == S_DIV, !rem[K] && rem[K-1:0] < len)
  `LSEE_ASSERT_HOLDS(a_len_nonzero, clk, rst, state == S_MUL, len != '0)
  `LSEE_ASSERT_HOLDS(a_quo_bound, clk, rst, state == S_SUM, quo <= extend_distance)
  `LSEE_ASSERT_HOLDS(a_last_is_added, clk, rst, out_valid && out_last, out_added)
  `LSEE_ASSERT_NEXT(a_first_stays_idle, clk, rst, in_take && phase == PH_NONE, state == S_IDLE)

endmodule

`default_nettype wire
